### src/gkpd_pkg.sv
// Shared types and constants of the gap-keeping PD speed controller.
package gkpd_pkg;

  // Item opcodes.
  typedef enum logic [1:0] {
    OP_DISTANCE = 2'd0,
    OP_SPEED    = 2'd1,
    OP_TARGET   = 2'd2,
    OP_TICK     = 2'd3
  } opcode_e;

  // Result causes.
  typedef enum logic [1:0] {
    CAUSE_CONTROL       = 2'd0,
    CAUSE_EMERGENCY     = 2'd1,
    CAUSE_RANGE_TIMEOUT = 2'd2,
    CAUSE_SPEED_TIMEOUT = 2'd3
  } cause_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_PROP_GAIN     = 2'd0,
    REG_DERIV_GAIN    = 2'd1,
    REG_EMERGENCY_GAP = 2'd2,
    REG_MINIMUM_GAP   = 2'd3
  } cfg_reg_e;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_TICK   = 9'b000000010,
    S_CHECK  = 9'b000000100,
    S_DIV    = 9'b000001000,
    S_DEAD   = 9'b000010000,
    S_MULP   = 9'b000100000,
    S_MULD   = 9'b001000000,
    S_SAT    = 9'b010000000,
    S_RESULT = 9'b100000000
  } state_e;

  localparam logic signed [15:0] EMERGENCY_SPEED = -16'sd5000;
  localparam logic [16:0]        DEADBAND_MM     = 17'd50;
  localparam logic [25:0]        DEADBAND_MMPS   = 26'd50;
  localparam logic [9:0]         MS_PER_S        = 10'd1000;

  // |gap change| * 1000 fits in 26 bits; one quotient bit per divider step.
  localparam int unsigned        NUM_W           = 26;
  localparam logic [4:0]         DIV_STEPS       = 5'd26;

  localparam logic [15:0]        PROP_GAIN_RST   = 16'd256;
  localparam logic [15:0]        DERIV_GAIN_RST  = 16'd256;
  localparam logic [15:0]        EMERG_GAP_RST   = 16'd800;
  localparam logic [15:0]        MIN_GAP_RST     = 16'd2000;

endpackage

### src/gap_keeping_pd_speed_controller.sv
// Top level of the gap-keeping PD speed controller: sequencer, serial divider, shared multiplier.
//
// Takes one item per transfer: a distance sample with a millisecond timestamp, an own-speed
// sample, a new target gap (clamped up to minimum_gap_mm) or a watchdog tick. Lengths are mm,
// speeds mm/s, gains unsigned Q8.8. From the second distance sample on, with positive elapsed
// time, relative speed is (previous - current) * 1000 / dt; the block then issues the
// emergency speed of -5000 mm/s (cause 1), nothing inside the 50 mm / 50 mm/s deadband, or
// own speed + kp*(gap - target) - kd*rel, saturated to 16 bits (cause 0). A tick issues a zero
// speed for each source not seen since the last tick (cause 2 range, then cause 3 speed), with
// last set on the final one. Items are handled one at a time and in_stall_o stays high while
// one is in work. A distance sample that reaches the control law passes through the 26-step
// restoring divider that forms relative speed, then two passes through the one 17x17
// multiplier and a saturation step. Any result waits in the output register until taken;
// a stalled output holds back the next result and, with it, further items.
// Configuration writes land at once and are meant for idle periods.
module gap_keeping_pd_speed_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [16:0] value_i,
  input  logic [31:0]        sample_time_ms_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] speed_cmd_o,
  output logic [1:0]         cause_o,
  output logic               last_o,
  // configuration
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  gkpd_pkg::state_e state_q, state_d;

  // configuration registers
  logic [15:0] prop_gain_q, deriv_gain_q, emerg_gap_q, min_gap_q;

  // tracked state
  logic [15:0]        prior_gap_q, latest_gap_q, target_gap_q;
  logic [31:0]        prior_time_q, latest_time_q;
  logic [1:0]         held_q;
  logic signed [15:0] own_speed_q;
  logic [1:0]         seen_q;   // bit 0 range, bit 1 speed
  logic [1:0]         pend_q;   // timeouts still to report for the current tick

  // datapath registers
  logic [30:0]                  dt_q;
  logic                         d_neg_q;
  logic signed [16:0]           err_q;
  logic [31:0]                  rem_q;
  logic [gkpd_pkg::NUM_W-1:0]   quo_q;
  logic [4:0]                   div_cnt_q;
  logic signed [15:0]           rel_q;
  logic signed [33:0]           prod_q;
  logic signed [35:0]           acc_q;
  logic signed [15:0]           res_q;
  gkpd_pkg::cause_e             res_cause_q;

  // output register
  logic               out_valid_q;
  logic signed [15:0] speed_q;
  gkpd_pkg::cause_e   cause_q;
  logic               last_q;

  logic in_acc, out_free;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != gkpd_pkg::S_IDLE);

  // Gap change and error, taken from the already shifted sample pair.
  logic signed [16:0]         d_cmb, err_cmb;
  logic [15:0]                d_mag;
  logic [gkpd_pkg::NUM_W-1:0] num_mag;
  logic [31:0]                dt_raw;
  assign d_cmb   = $signed({1'b0, prior_gap_q}) - $signed({1'b0, latest_gap_q});
  assign err_cmb = $signed({1'b0, latest_gap_q}) - $signed({1'b0, target_gap_q});
  assign d_mag   = d_cmb[16] ? 16'(-d_cmb) : d_cmb[15:0];
  assign num_mag = gkpd_pkg::NUM_W'(d_mag) * gkpd_pkg::NUM_W'(gkpd_pkg::MS_PER_S);
  assign dt_raw  = latest_time_q - prior_time_q;

  // One restoring divider step.
  logic [31:0] rem_shift;
  logic        rem_ge;
  assign rem_shift = {rem_q[30:0], quo_q[gkpd_pkg::NUM_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, dt_q});

  // Deadband test and saturated relative speed from the quotient.
  logic [16:0]        err_mag;
  logic               in_dead;
  logic signed [15:0] rel_cmb;
  assign err_mag = err_q[16] ? 17'(-err_q) : err_q;
  assign in_dead = (quo_q < gkpd_pkg::DEADBAND_MMPS) && (err_mag < gkpd_pkg::DEADBAND_MM);
  always_comb begin
    if (d_neg_q) begin
      rel_cmb = (quo_q > gkpd_pkg::NUM_W'(32768)) ? 16'sh8000 : 16'(-quo_q[15:0]);
    end else begin
      rel_cmb = (quo_q > gkpd_pkg::NUM_W'(32767)) ? 16'sh7fff : $signed(quo_q[15:0]);
    end
  end

  // Shared multiplier: kp * err, then kd * rel.
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_p;
  always_comb begin
    if (state_q == gkpd_pkg::S_MULD) begin
      mul_a = $signed({1'b0, deriv_gain_q});
      mul_b = {rel_q[15], rel_q};
    end else begin
      mul_a = $signed({1'b0, prop_gain_q});
      mul_b = err_q;
    end
  end
  assign mul_p = mul_a * mul_b;

  // Final sum, floor by 256, saturate.
  logic signed [35:0] sum_cmb;
  logic signed [15:0] sat_cmb;
  assign sum_cmb = acc_q - {{2{prod_q[33]}}, prod_q};
  always_comb begin
    if (sum_cmb[35:23] == {13{sum_cmb[35]}}) begin
      sat_cmb = sum_cmb[23:8];
    end else begin
      sat_cmb = sum_cmb[35] ? 16'sh8000 : 16'sh7fff;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      gkpd_pkg::S_IDLE: begin
        if (in_acc) begin
          case (gkpd_pkg::opcode_e'(opcode_i))
            gkpd_pkg::OP_DISTANCE: begin
              if (held_q != 2'd0) state_d = gkpd_pkg::S_CHECK;
            end
            gkpd_pkg::OP_TICK: begin
              if (seen_q != 2'b11) state_d = gkpd_pkg::S_TICK;
            end
            default: state_d = gkpd_pkg::S_IDLE;
          endcase
        end
      end
      gkpd_pkg::S_TICK: begin
        if (out_free && (pend_q != 2'b11)) state_d = gkpd_pkg::S_IDLE;
      end
      gkpd_pkg::S_CHECK: begin
        if (dt_raw[31] || (dt_raw == 32'd0)) begin
          state_d = gkpd_pkg::S_IDLE;
        end else if ((latest_gap_q <= emerg_gap_q) && d_cmb[16]) begin
          state_d = gkpd_pkg::S_RESULT;
        end else begin
          state_d = gkpd_pkg::S_DIV;
        end
      end
      gkpd_pkg::S_DIV: begin
        if (div_cnt_q == 5'd1) state_d = gkpd_pkg::S_DEAD;
      end
      gkpd_pkg::S_DEAD:   state_d = in_dead ? gkpd_pkg::S_IDLE : gkpd_pkg::S_MULP;
      gkpd_pkg::S_MULP:   state_d = gkpd_pkg::S_MULD;
      gkpd_pkg::S_MULD:   state_d = gkpd_pkg::S_SAT;
      gkpd_pkg::S_SAT:    state_d = gkpd_pkg::S_RESULT;
      gkpd_pkg::S_RESULT: begin
        if (out_free) state_d = gkpd_pkg::S_IDLE;
      end
      default: state_d = gkpd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gkpd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= gkpd_pkg::PROP_GAIN_RST;
      deriv_gain_q <= gkpd_pkg::DERIV_GAIN_RST;
      emerg_gap_q  <= gkpd_pkg::EMERG_GAP_RST;
      min_gap_q    <= gkpd_pkg::MIN_GAP_RST;
    end else if (cfg_we_i) begin
      case (gkpd_pkg::cfg_reg_e'(cfg_index_i))
        gkpd_pkg::REG_PROP_GAIN:     prop_gain_q  <= cfg_data_i;
        gkpd_pkg::REG_DERIV_GAIN:    deriv_gain_q <= cfg_data_i;
        gkpd_pkg::REG_EMERGENCY_GAP: emerg_gap_q  <= cfg_data_i;
        gkpd_pkg::REG_MINIMUM_GAP:   min_gap_q    <= cfg_data_i;
        default:                     prop_gain_q  <= prop_gain_q;
      endcase
    end
  end

  // Tracked state: updated in the accept cycle, and the pending timeout marks while a tick reports.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_gap_q   <= '0;
      latest_gap_q  <= '0;
      prior_time_q  <= '0;
      latest_time_q <= '0;
      held_q        <= '0;
      own_speed_q   <= '0;
      target_gap_q  <= '0;
      seen_q        <= '0;
      pend_q        <= '0;
    end else if (state_q == gkpd_pkg::S_IDLE && in_acc) begin
      case (gkpd_pkg::opcode_e'(opcode_i))
        gkpd_pkg::OP_DISTANCE: begin
          seen_q[0]     <= 1'b1;
          prior_gap_q   <= latest_gap_q;
          // negative distances read as zero
          latest_gap_q  <= value_i[16] ? 16'd0 : value_i[15:0];
          prior_time_q  <= latest_time_q;
          latest_time_q <= sample_time_ms_i;
          if (held_q != 2'd2) held_q <= held_q + 2'd1;
        end
        gkpd_pkg::OP_SPEED: begin
          seen_q[1] <= 1'b1;
          case (value_i[16:15])
            2'b01:   own_speed_q <= 16'sh7fff;
            2'b10:   own_speed_q <= 16'sh8000;
            default: own_speed_q <= value_i[15:0];
          endcase
        end
        gkpd_pkg::OP_TARGET: begin
          // clamp up to the minimum gap, negative requests included
          if (value_i < $signed({1'b0, min_gap_q})) begin
            target_gap_q <= min_gap_q;
          end else begin
            target_gap_q <= value_i[15:0];
          end
        end
        default: begin
          pend_q <= ~seen_q;
          seen_q <= 2'b00;
        end
      endcase
    end else if (state_q == gkpd_pkg::S_TICK && out_free) begin
      // report the range timeout first, then the speed timeout
      if (pend_q[0]) begin
        pend_q[0] <= 1'b0;
      end else begin
        pend_q[1] <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      gkpd_pkg::S_CHECK: begin
        dt_q        <= dt_raw[30:0];
        d_neg_q     <= d_cmb[16];
        err_q       <= err_cmb;
        rem_q       <= '0;
        quo_q       <= num_mag;
        div_cnt_q   <= gkpd_pkg::DIV_STEPS;
        res_q       <= gkpd_pkg::EMERGENCY_SPEED;
        res_cause_q <= gkpd_pkg::CAUSE_EMERGENCY;
      end
      gkpd_pkg::S_DIV: begin
        rem_q     <= rem_ge ? (rem_shift - {1'b0, dt_q}) : rem_shift;
        quo_q     <= {quo_q[gkpd_pkg::NUM_W-2:0], rem_ge};
        div_cnt_q <= div_cnt_q - 5'd1;
      end
      gkpd_pkg::S_DEAD: begin
        rel_q <= rel_cmb;
      end
      gkpd_pkg::S_MULP: begin
        prod_q <= mul_p;
        acc_q  <= {{12{own_speed_q[15]}}, own_speed_q, 8'd0};
      end
      gkpd_pkg::S_MULD: begin
        prod_q <= mul_p;
        acc_q  <= acc_q + {{2{prod_q[33]}}, prod_q};
      end
      gkpd_pkg::S_SAT: begin
        res_q       <= sat_cmb;
        res_cause_q <= gkpd_pkg::CAUSE_CONTROL;
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  // Output register: hold until the transfer completes.
  logic load_tick, load_res;
  assign load_tick = (state_q == gkpd_pkg::S_TICK) && out_free;
  assign load_res  = (state_q == gkpd_pkg::S_RESULT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_tick || load_res) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      speed_q <= res_q;
      cause_q <= res_cause_q;
      last_q  <= 1'b1;
    end else if (load_tick) begin
      speed_q <= '0;
      cause_q <= pend_q[0] ? gkpd_pkg::CAUSE_RANGE_TIMEOUT : gkpd_pkg::CAUSE_SPEED_TIMEOUT;
      last_q  <= !(pend_q[0] && pend_q[1]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign speed_cmd_o = speed_q;
  assign cause_o     = cause_q;
  assign last_o      = last_q;

`ifndef NO_ASSERTIONS
  // The sequencer is always in exactly one state.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("sequencer state not one-hot");

  // A tick with both sources seen reports nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == gkpd_pkg::OP_TICK && seen_q == 2'b11) |=> state_q == gkpd_pkg::S_IDLE)
    else $error("tick with both sources seen started a report");

  // The first distance sample after reset never reaches the control law.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == gkpd_pkg::OP_DISTANCE && held_q == 2'd0)
      |=> state_q == gkpd_pkg::S_IDLE)
    else $error("single distance sample started a computation");

  // Only the range timeout of a double report is not the final result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> cause_o == gkpd_pkg::CAUSE_RANGE_TIMEOUT)
    else $error("non-final result with unexpected cause");
`endif

endmodule
